/* rtl/matrix3x3_inverse_assert.svh */
// Assertion macros shared by the matrix inverse block.
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MI3_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define MI3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

/* rtl/mi3_pkg.sv */
`timescale 1ns / 1ps
package mi3_pkg;

  // Fixed field widths.
  localparam int ENTRY_W  = 16;
  localparam int PROD_W   = 2 * ENTRY_W;
  localparam int COF_W    = PROD_W + 1;
  localparam int DP_W     = ENTRY_W + COF_W;
  localparam int DETX_W   = DP_W + 2;
  localparam int DET_W    = 48;
  localparam int THR_W    = 47;
  localparam int OUT_W    = 32;
  localparam int OUT_FRAC = 16;
  localparam int QB       = OUT_W + 1;

  // Default fraction bits of the input entries.
  localparam int FRAC_BITS_DEF = 8;

  // Threshold after reset.
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(17);

  // Identity diagonal value in Q16.16.
  localparam logic signed [OUT_W-1:0] ONE_Q = OUT_W'(1) << OUT_FRAC;

  // Stages ahead of the divider lanes.
  localparam int FRONT_LAT = 6;
  // Divider lane stages.
  localparam int LANE_LAT  = QB + 1;
  // Total latency including the output register.
  localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + 1;

  typedef struct packed {
    logic signed [ENTRY_W-1:0] a_00;
    logic signed [ENTRY_W-1:0] a_01;
    logic signed [ENTRY_W-1:0] a_02;
    logic signed [ENTRY_W-1:0] a_10;
    logic signed [ENTRY_W-1:0] a_11;
    logic signed [ENTRY_W-1:0] a_12;
    logic signed [ENTRY_W-1:0] a_20;
    logic signed [ENTRY_W-1:0] a_21;
    logic signed [ENTRY_W-1:0] a_22;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] inv_00;
    logic signed [OUT_W-1:0] inv_01;
    logic signed [OUT_W-1:0] inv_02;
    logic signed [OUT_W-1:0] inv_10;
    logic signed [OUT_W-1:0] inv_11;
    logic signed [OUT_W-1:0] inv_12;
    logic signed [OUT_W-1:0] inv_20;
    logic signed [OUT_W-1:0] inv_21;
    logic signed [OUT_W-1:0] inv_22;
    logic                    is_singular;
    logic signed [DET_W-1:0] det_value;
  } out_t;

endpackage

/* rtl/mi3_front.sv */
`timescale 1ns / 1ps
module mi3_front import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NW = COF_W + FRAC_BITS + OUT_FRAC + 1,
  localparam int RW = ((NW > DETX_W + QB) ? NW : DETX_W + QB) + 1
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  in_t                 data_i,
  input  logic [THR_W-1:0]    thr_i,
  output logic [RW-1:0]       num_o [9],
  output logic [DETX_W-1:0]   den_o,
  output logic [8:0]          neg_o,
  output logic                singular_o,
  output logic signed [DET_W-1:0] det_sat_o
);

  // Operand pairs of the eighteen minor products.
  localparam int PA [18] = '{4, 5, 3, 5, 3, 4, 1, 2, 0, 2, 0, 1, 1, 2, 0, 2, 0, 1};
  localparam int PB [18] = '{8, 7, 8, 6, 7, 6, 8, 7, 8, 6, 7, 6, 5, 4, 5, 3, 4, 3};

  in_t in_q;
  logic signed [ENTRY_W-1:0] m [9];
  logic signed [PROD_W-1:0]  prod_q [18];
  logic signed [ENTRY_W-1:0] row0_q2 [3];
  logic signed [ENTRY_W-1:0] row0_q3 [3];
  logic signed [COF_W-1:0]   cof_q3 [9];
  logic signed [COF_W-1:0]   cof_q4 [9];
  logic signed [COF_W-1:0]   cof_q5 [9];
  logic signed [DP_W-1:0]    dprod_q4 [3];
  logic signed [DETX_W-1:0]  det_q5;
  logic [DETX_W-1:0]         det_mag;

  assign m[0] = in_q.a_00;
  assign m[1] = in_q.a_01;
  assign m[2] = in_q.a_02;
  assign m[3] = in_q.a_10;
  assign m[4] = in_q.a_11;
  assign m[5] = in_q.a_12;
  assign m[6] = in_q.a_20;
  assign m[7] = in_q.a_21;
  assign m[8] = in_q.a_22;

  // Input register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_q <= data_i;
    end
  end

  // Minor products, one multiplier each.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 18; k++) begin
        prod_q[k] <= PROD_W'(m[PA[k]]) * PROD_W'(m[PB[k]]);
      end
      for (int j = 0; j < 3; j++) begin
        row0_q2[j] <= m[j];
      end
    end
  end

  // Cofactors with checkerboard signs.
  always_ff @(posedge clk_i) begin
    logic signed [COF_W-1:0] diff;
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        diff = COF_W'(prod_q[2*k]) - COF_W'(prod_q[2*k+1]);
        cof_q3[k] <= k[0] ? -diff : diff;
      end
      row0_q3 <= row0_q2;
    end
  end

  // Row 0 expansion products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < 3; j++) begin
        dprod_q4[j] <= DP_W'(row0_q3[j]) * DP_W'(cof_q3[j]);
      end
      cof_q4 <= cof_q3;
    end
  end

  // Determinant sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det_q5 <= DETX_W'(dprod_q4[0]) + DETX_W'(dprod_q4[1]) + DETX_W'(dprod_q4[2]);
      cof_q5 <= cof_q4;
    end
  end

  assign det_mag = det_q5[DETX_W-1] ? DETX_W'(-det_q5) : DETX_W'(det_q5);

  // Singular test, saturated determinant and divider operands.
  always_ff @(posedge clk_i) begin
    logic [COF_W-1:0] cmag;
    logic signed [COF_W-1:0] cs;
    if (en_i) begin
      singular_o <= (det_q5 == '0) || (det_mag < DETX_W'(thr_i));
      if (det_q5[DETX_W-1:DET_W-1] == '0 || det_q5[DETX_W-1:DET_W-1] == '1) begin
        det_sat_o <= det_q5[DET_W-1:0];
      end else if (det_q5[DETX_W-1]) begin
        det_sat_o <= {1'b1, {(DET_W-1){1'b0}}};
      end else begin
        det_sat_o <= {1'b0, {(DET_W-1){1'b1}}};
      end
      den_o <= det_mag;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          cs = cof_q5[c*3+r];
          cmag = cs[COF_W-1] ? COF_W'(-cs) : COF_W'(cs);
          num_o[r*3+c] <= (RW'(cmag) << (FRAC_BITS + OUT_FRAC)) + RW'(det_mag >> 1);
          neg_o[r*3+c] <= cs[COF_W-1] ^ det_q5[DETX_W-1];
        end
      end
    end
  end

endmodule

/* rtl/mi3_div_lane.sv */
`timescale 1ns / 1ps
module mi3_div_lane import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NW = COF_W + FRAC_BITS + OUT_FRAC + 1,
  localparam int RW = ((NW > DETX_W + QB) ? NW : DETX_W + QB) + 1
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [RW-1:0]           num_i,
  input  logic [DETX_W-1:0]       den_i,
  input  logic                    neg_i,
  output logic signed [OUT_W-1:0] res_o
);

  localparam logic [QB-1:0] POS_MAX = (QB'(1) << (OUT_W - 1)) - QB'(1);
  localparam logic [QB-1:0] NEG_MAX = QB'(1) << (OUT_W - 1);

  logic [RW-1:0]     rem_q [QB+1];
  logic [DETX_W-1:0] den_q [QB+1];
  logic [QB-1:0]     quo_q [QB+1];
  logic [QB:0]       neg_q;
  logic [QB:0]       ovf_q;

  // First stage flags quotients too large for the bit stages.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      neg_q[0] <= neg_i;
      ovf_q[0] <= num_i >= (RW'(den_i) << QB);
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar s = 1; s <= QB; s++) begin : g_bit
    logic [RW-1:0] dsh;
    assign dsh = RW'(den_q[s-1]) << (QB - s);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        if (rem_q[s-1] >= dsh) begin
          rem_q[s] <= rem_q[s-1] - dsh;
          quo_q[s] <= quo_q[s-1] | (QB'(1) << (QB - s));
        end else begin
          rem_q[s] <= rem_q[s-1];
          quo_q[s] <= quo_q[s-1];
        end
      end
    end
  end

  // Apply the sign and saturate to the output range.
  always_comb begin
    if (neg_q[QB]) begin
      if (ovf_q[QB] || quo_q[QB] > NEG_MAX) begin
        res_o = {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
        res_o = -quo_q[QB][OUT_W-1:0];
      end
    end else begin
      if (ovf_q[QB] || quo_q[QB] > POS_MAX) begin
        res_o = {1'b0, {(OUT_W-1){1'b1}}};
      end else begin
        res_o = quo_q[QB][OUT_W-1:0];
      end
    end
  end

endmodule

/* rtl/matrix3x3_inverse.sv */
`timescale 1ns / 1ps
// 3x3 matrix inverse by the adjugate, one signed Q8.8 matrix per transaction.
// Input channel: in_valid_i / in_stall_o with in_data_i; a transaction is taken
// on a rising edge with valid high and stall low. Output channel: out_valid_o /
// out_stall_i with out_data_o carrying the Q16.16 inverse, the singular flag and
// the Q24.24 determinant.
// Configuration: cfg_valid_i / cfg_ready_o writes the 47-bit singular
// threshold; ready is always high. Write it only while the block is empty.
// Throughput is one matrix per cycle unless stalled. Six stages form the
// minors, cofactors and determinant, nine divider lanes of 34 stages flag
// overflow and resolve one quotient bit per stage, and one register merges the
// lanes. A stalled valid output freezes the whole pipeline, and in_stall_o
// follows it. Reset empties the pipeline and restores the threshold to 17.
module matrix3x3_inverse import mi3_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  localparam int NW = COF_W + FRAC_BITS + OUT_FRAC + 1,
  localparam int RW = ((NW > DETX_W + QB) ? NW : DETX_W + QB) + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [THR_W-1:0] cfg_data_i
);

  logic                    en;
  logic [THR_W-1:0]        thr_q;
  logic [TOTAL_LAT-1:0]    valid_q;
  logic [RW-1:0]           num [9];
  logic [DETX_W-1:0]       den;
  logic [8:0]              neg;
  logic                    singular;
  logic signed [DET_W-1:0] det_sat;
  logic signed [OUT_W-1:0] res [9];
  logic [LANE_LAT-1:0]     sing_q;
  logic signed [DET_W-1:0] dsat_q [LANE_LAT];
  out_t                    out_d;
  out_t                    out_q;

  // The pipeline moves unless a finished transaction is held at the output.
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  // Valid bits along the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[TOTAL_LAT-2:0], in_valid_i};
    end
  end

  mi3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i      (clk_i),
    .en_i       (en),
    .data_i     (in_data_i),
    .thr_i      (thr_q),
    .num_o      (num),
    .den_o      (den),
    .neg_o      (neg),
    .singular_o (singular),
    .det_sat_o  (det_sat)
  );

  // One divider lane per inverse entry.
  for (genvar l = 0; l < 9; l++) begin : g_lane
    mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num[l]),
      .den_i (den),
      .neg_i (neg[l]),
      .res_o (res[l])
    );
  end

  // Singular flag and determinant travel alongside the lanes.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sing_q    <= {sing_q[LANE_LAT-2:0], singular};
      dsat_q[0] <= det_sat;
      for (int s = 1; s < LANE_LAT; s++) begin
        dsat_q[s] <= dsat_q[s-1];
      end
    end
  end

  // Merge the lanes, substituting the identity for a singular matrix.
  always_comb begin
    logic sg;
    sg = sing_q[LANE_LAT-1];
    out_d.inv_00      = sg ? ONE_Q : res[0];
    out_d.inv_01      = sg ? '0    : res[1];
    out_d.inv_02      = sg ? '0    : res[2];
    out_d.inv_10      = sg ? '0    : res[3];
    out_d.inv_11      = sg ? ONE_Q : res[4];
    out_d.inv_12      = sg ? '0    : res[5];
    out_d.inv_20      = sg ? '0    : res[6];
    out_d.inv_21      = sg ? '0    : res[7];
    out_d.inv_22      = sg ? ONE_Q : res[8];
    out_d.is_singular = sg;
    out_d.det_value   = dsat_q[LANE_LAT-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = valid_q[TOTAL_LAT-1];
  assign out_data_o  = out_q;

`include "matrix3x3_inverse_assert.svh"

  `MI3_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_valid_i && !in_stall_o, valid_q[0])
  `MI3_ASSERT_IMPLY(a_zero_det_singular, clk_i, rst_ni, out_valid_o && out_data_o.det_value == '0, out_data_o.is_singular)
  `MI3_ASSERT_IMPLY(a_singular_identity, clk_i, rst_ni, out_valid_o && out_data_o.is_singular, out_data_o.inv_00 == ONE_Q && out_data_o.inv_01 == '0 && out_data_o.inv_22 == ONE_Q)

endmodule

/* tb/sv/tb_matrix3x3_inverse.sv */
`timescale 1ns / 1ps
module tb_matrix3x3_inverse;
  import mi3_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    in_t  mat;
    bit   typed;
    out_t want;
  } row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_t              in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_t             out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [THR_W-1:0] cfg_data_i;

  // Threshold as the block should currently hold it.
  logic [THR_W-1:0] thr_now;
  out_t             inverse_q[$];
  int               n_sent;
  int               n_errors;
  int               cycle_cnt;
  logic             hold_req;
  int               stall_left;

  matrix3x3_inverse i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Rounded, saturated quotient cof * 2^(FRAC_BITS+16) / det.
  function automatic longint scaled_quot(longint cof, longint det);
    bit [63:0] num;
    bit [63:0] den;
    bit [63:0] q;
    bit        neg;
    num = (cof < 0 ? -cof : cof);
    num = num << (FRAC_BITS_DEF + OUT_FRAC);
    den = (det < 0 ? -det : det);
    q = (num + (den >> 1)) / den;
    neg = (cof < 0) != (det < 0);
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -longint'(q);
    end
    if (q > 64'h7fff_ffff) q = 64'h7fff_ffff;
    return longint'(q);
  endfunction

  // Inverse by the adjugate, with the singular fallback to identity.
  function automatic out_t invert(in_t a, logic [THR_W-1:0] thr);
    longint m[9];
    longint cf[9];
    longint det;
    longint mag_det;
    longint w[9];
    bit     sing;
    out_t   o;
    m[0] = a.a_00; m[1] = a.a_01; m[2] = a.a_02;
    m[3] = a.a_10; m[4] = a.a_11; m[5] = a.a_12;
    m[6] = a.a_20; m[7] = a.a_21; m[8] = a.a_22;
    cf[0] =  (m[4] * m[8] - m[5] * m[7]);
    cf[1] = -(m[3] * m[8] - m[5] * m[6]);
    cf[2] =  (m[3] * m[7] - m[4] * m[6]);
    cf[3] = -(m[1] * m[8] - m[2] * m[7]);
    cf[4] =  (m[0] * m[8] - m[2] * m[6]);
    cf[5] = -(m[0] * m[7] - m[1] * m[6]);
    cf[6] =  (m[1] * m[5] - m[2] * m[4]);
    cf[7] = -(m[0] * m[5] - m[2] * m[3]);
    cf[8] =  (m[0] * m[4] - m[1] * m[3]);
    det = m[0] * cf[0] + m[1] * cf[1] + m[2] * cf[2];
    mag_det = det < 0 ? -det : det;
    sing = (det == 0) || (mag_det < longint'({17'd0, thr}));
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (sing) w[r*3+c] = (r == c) ? longint'(ONE_Q) : 0;
        else w[r*3+c] = scaled_quot(cf[c*3+r], det);
      end
    end
    o.inv_00 = w[0][31:0]; o.inv_01 = w[1][31:0]; o.inv_02 = w[2][31:0];
    o.inv_10 = w[3][31:0]; o.inv_11 = w[4][31:0]; o.inv_12 = w[5][31:0];
    o.inv_20 = w[6][31:0]; o.inv_21 = w[7][31:0]; o.inv_22 = w[8][31:0];
    o.is_singular = sing;
    if (det > 64'sh7fff_ffff_ffff) det = 64'sh7fff_ffff_ffff;
    if (det < -64'sh8000_0000_0000) det = -64'sh8000_0000_0000;
    o.det_value = det[47:0];
    return o;
  endfunction

  // Identity result, typed in for the directed rows.
  function automatic out_t identity_out(bit sing, logic [DET_W-1:0] det);
    out_t o;
    o = '0;
    o.inv_00 = ONE_Q;
    o.inv_11 = ONE_Q;
    o.inv_22 = ONE_Q;
    o.is_singular = sing;
    o.det_value = det;
    return o;
  endfunction

  function automatic in_t diag(logic [15:0] d, logic [15:0] off);
    return in_t'{d, off, off, off, d, off, off, off, d};
  endfunction

  // Random matrix drawn from one of several shapes.
  function automatic in_t random_matrix();
    in_t x;
    int  mode;
    mode = $urandom_range(0, 9);
    x = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    case (mode)
      5, 6: begin
        x = in_t'({9{16'h0}});
        x.a_00 = 16'($urandom_range(0, 1023) - 512);
        x.a_01 = 16'($urandom_range(0, 1023) - 512);
        x.a_02 = 16'($urandom_range(0, 1023) - 512);
        x.a_10 = 16'($urandom_range(0, 1023) - 512);
        x.a_11 = 16'($urandom_range(0, 1023) - 512);
        x.a_12 = 16'($urandom_range(0, 1023) - 512);
        x.a_20 = 16'($urandom_range(0, 1023) - 512);
        x.a_21 = 16'($urandom_range(0, 1023) - 512);
        x.a_22 = 16'($urandom_range(0, 1023) - 512);
      end
      7: begin
        // Repeated row gives a zero determinant.
        x.a_20 = x.a_10; x.a_21 = x.a_11; x.a_22 = x.a_12;
      end
      8: begin
        x.a_00 = 16'(256 + $urandom_range(0, 63) - 32);
        x.a_11 = 16'(256 + $urandom_range(0, 63) - 32);
        x.a_22 = 16'(256 + $urandom_range(0, 63) - 32);
        x.a_01 = 16'($urandom_range(0, 63) - 32); x.a_02 = 16'($urandom_range(0, 63) - 32);
        x.a_10 = 16'($urandom_range(0, 63) - 32); x.a_12 = 16'($urandom_range(0, 63) - 32);
        x.a_20 = 16'($urandom_range(0, 63) - 32); x.a_21 = 16'($urandom_range(0, 63) - 32);
      end
      9: begin
        x.a_00 = 16'($urandom_range(0, 8) - 4); x.a_01 = 16'($urandom_range(0, 8) - 4);
        x.a_02 = 16'($urandom_range(0, 8) - 4); x.a_10 = 16'($urandom_range(0, 8) - 4);
        x.a_11 = 16'($urandom_range(0, 8) - 4); x.a_12 = 16'($urandom_range(0, 8) - 4);
        x.a_20 = 16'($urandom_range(0, 8) - 4); x.a_21 = 16'($urandom_range(0, 8) - 4);
        x.a_22 = 16'($urandom_range(0, 8) - 4);
      end
      default: ;
    endcase
    return x;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one matrix and hold it until the block takes it.
  task automatic send_matrix(in_t x, out_t want);
    in_valid_i <= 1'b1;
    in_data_i  <= x;
    do @(posedge clk_i); while (in_stall_o);
    inverse_q.push_back(want);
    n_sent++;
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Let the pipeline drain, then write the threshold.
  task automatic write_threshold(logic [THR_W-1:0] v);
    idle_for(1);
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (TOTAL_LAT) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    thr_now = v;
  endtask

  task automatic run_random(int count, bit pause_mid);
    int burst;
    burst = 0;
    for (int k = 0; k < count; k++) begin
      send_matrix(random_matrix(), 'x);
      inverse_q[$] = invert(in_data_i, thr_now);
      if (pause_mid && k == count / 2) begin
        // Sender waits for every outstanding result.
        idle_for(1);
        while (inverse_q.size() != 0) @(posedge clk_i);
      end else if (burst > 0) begin
        burst--;
      end else if ($urandom_range(0, 49) == 0) begin
        burst = $urandom_range(20, 60);
      end else begin
        idle_for(pick_gap());
      end
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (n_errors < MAX_REPORTS)
        $display("mismatch %s: expected %h, got %h", name, want, got);
      n_errors++;
    end
  endtask

  // Output side: compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        if (n_errors < MAX_REPORTS) $display("unexpected result %h", out_data_o);
        n_errors++;
      end else begin
        want = inverse_q.pop_front();
        check_field("inv_00", 64'(want.inv_00), 64'(out_data_o.inv_00));
        check_field("inv_01", 64'(want.inv_01), 64'(out_data_o.inv_01));
        check_field("inv_02", 64'(want.inv_02), 64'(out_data_o.inv_02));
        check_field("inv_10", 64'(want.inv_10), 64'(out_data_o.inv_10));
        check_field("inv_11", 64'(want.inv_11), 64'(out_data_o.inv_11));
        check_field("inv_12", 64'(want.inv_12), 64'(out_data_o.inv_12));
        check_field("inv_20", 64'(want.inv_20), 64'(out_data_o.inv_20));
        check_field("inv_21", 64'(want.inv_21), 64'(out_data_o.inv_21));
        check_field("inv_22", 64'(want.inv_22), 64'(out_data_o.inv_22));
        check_field("is_singular", 64'(want.is_singular), 64'(out_data_o.is_singular));
        check_field("det_value", 64'(want.det_value), 64'(out_data_o.det_value));
      end
    end
  end

  // Receiver stalls: mostly short runs, a few long ones, plus forced holds.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (hold_req) begin
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 88) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= 1'b1;
      stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(0, 2);
    end
  end

  // Long receiver hold while the sender keeps offering matrices.
  initial begin
    hold_req = 1'b0;
    wait (n_sent >= 400);
    @(posedge clk_i);
    hold_req <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_req <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus: directed table, then random phases under several thresholds.
  initial begin
    row_t rows[$];
    row_t rw;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    thr_now     = THR_RESET;
    n_sent      = 0;
    n_errors    = 0;
    cycle_cnt   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rw.typed = 1'b1;
    rw.mat = diag(16'h0100, 16'h0000); rw.want = identity_out(1'b0, 48'd16777216);
    rows.push_back(rw);
    rw.mat = diag(16'h0000, 16'h0000); rw.want = identity_out(1'b1, 48'd0);
    rows.push_back(rw);
    rw.mat = diag(16'h7fff, 16'h7fff); rw.want = identity_out(1'b1, 48'd0);
    rows.push_back(rw);
    rw.mat = diag(16'h8000, 16'h8000); rw.want = identity_out(1'b1, 48'd0);
    rows.push_back(rw);
    // Determinant of one LSB, below the reset threshold.
    rw.mat = diag(16'h0001, 16'h0000); rw.want = identity_out(1'b1, 48'd1);
    rows.push_back(rw);
    rw.typed = 1'b0;
    rw.mat = diag(16'h7fff, 16'h0000);  rows.push_back(rw);
    rw.mat = diag(16'h8000, 16'h0000);  rows.push_back(rw);
    rw.mat = diag(16'h0002, 16'h0000);  rows.push_back(rw);
    rw.mat = diag(16'h0003, 16'h0000);  rows.push_back(rw);
    rw.mat = diag(16'hffff, 16'h0000);  rows.push_back(rw);
    rw.mat = diag(16'h0100, 16'h0080);  rows.push_back(rw);
    rw.mat = diag(16'h8000, 16'h7fff);  rows.push_back(rw);
    rw.mat = in_t'{16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
                   16'h0100, 16'h0000, 16'h0000};
    rows.push_back(rw);
    rw.mat = in_t'{16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000,
                   16'h0100, 16'hff00, 16'h7fff};
    rows.push_back(rw);
    rw.mat = in_t'{16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000,
                   16'h0000, 16'h0000, 16'h0100};
    rows.push_back(rw);
    foreach (rows[i]) begin
      send_matrix(rows[i].mat, rows[i].typed ? rows[i].want : invert(rows[i].mat, thr_now));
      idle_for(pick_gap());
    end

    write_threshold('0);
    run_random(450, 1'b0);
    write_threshold({THR_W{1'b1}});
    run_random(100, 1'b0);
    write_threshold(THR_W'($urandom) << $urandom_range(0, 15));
    run_random(450, 1'b1);
    write_threshold(THR_W'(1) << 36);
    run_random(450, 1'b0);
    write_threshold(THR_RESET);
    run_random(500, 1'b0);

    idle_for(1);
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (TOTAL_LAT + 20) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/mi3_pkg.sv
rtl/mi3_front.sv
rtl/mi3_div_lane.sv
rtl/matrix3x3_inverse.sv
tb/sv/tb_matrix3x3_inverse.sv
